/* src/ystc_pkg.sv */
package ystc_pkg;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_STR   = 3'd0,
      KIND_NULL  = 3'd1,
      KIND_BOOL  = 3'd2,
      KIND_INT   = 3'd3,
      KIND_FLOAT = 3'd4
   } kind_type;

   // Schema mode codes (code 3 is unused and resolves as core)
   localparam logic [1:0] MODE_FAILSAFE = 2'd0;
   localparam logic [1:0] MODE_JSON     = 2'd1;
   localparam logic [1:0] MODE_CORE     = 2'd2;

   // Integer automaton
   typedef enum logic [3:0] {
      IP_START = 4'd0,
      IP_SIGN  = 4'd1,
      IP_ZERO  = 4'd2,
      IP_DEC   = 4'd3,
      IP_HEX0  = 4'd4,
      IP_HEX   = 4'd5,
      IP_OCT0  = 4'd6,
      IP_OCT   = 4'd7,
      IP_DEAD  = 4'd8
   } int_phase_type;

   // Float automaton
   typedef enum logic [3:0] {
      FP_START  = 4'd0,
      FP_SIGN   = 4'd1,
      FP_DOT    = 4'd2,
      FP_FRAC   = 4'd3,
      FP_INT    = 4'd4,
      FP_INTDOT = 4'd5,
      FP_E      = 4'd6,
      FP_ESIGN  = 4'd7,
      FP_EXP    = 4'd8,
      FP_I      = 4'd9,
      FP_IN     = 4'd10,
      FP_INF    = 4'd11,
      FP_DEAD   = 4'd12
   } float_phase_type;

   // One input word as held in the input register
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty_req;
      logic       quoted;
   } scan_item_type;

   // Keyword table
   localparam int KW_COUNT  = 11;
   localparam int KW_MAXLEN = 5;

   localparam logic [KW_COUNT-1:0] KW_ALL_MASK  = 11'h7FF;
   // null, true, false, .nan
   localparam logic [KW_COUNT-1:0] KW_JSON_MASK = 11'h491;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
      '{"n", "u", "l", "l", 8'h00},
      '{"N", "u", "l", "l", 8'h00},
      '{"N", "U", "L", "L", 8'h00},
      '{"~", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "r", "u", "e", 8'h00},
      '{"T", "r", "u", "e", 8'h00},
      '{"T", "R", "U", "E", 8'h00},
      '{"f", "a", "l", "s", "e"},
      '{"F", "a", "l", "s", "e"},
      '{"F", "A", "L", "S", "E"},
      '{".", "n", "a", "n", 8'h00}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd4, 3'd4, 3'd4, 3'd1, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd4
   };

   localparam kind_type KW_KIND [KW_COUNT] = '{
      KIND_NULL, KIND_NULL, KIND_NULL, KIND_NULL,
      KIND_BOOL, KIND_BOOL, KIND_BOOL, KIND_BOOL, KIND_BOOL, KIND_BOOL,
      KIND_FLOAT
   };

   // Character count saturates here
   localparam logic [2:0] POS_MAX = 3'd7;

   // Character codes
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_SEVEN = "7";
   localparam logic [7:0] CH_NINE  = "9";
   localparam logic [7:0] CH_LC_A  = "a";
   localparam logic [7:0] CH_LC_F  = "f";
   localparam logic [7:0] CH_UC_A  = "A";
   localparam logic [7:0] CH_UC_F  = "F";
   localparam logic [7:0] CH_LC_E  = "e";
   localparam logic [7:0] CH_UC_E  = "E";
   localparam logic [7:0] CH_LC_X  = "x";
   localparam logic [7:0] CH_LC_O  = "o";
   localparam logic [7:0] CH_LC_I  = "i";
   localparam logic [7:0] CH_LC_N  = "n";

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_SEVEN);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
             ((c >= CH_UC_A) && (c <= CH_UC_F));
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic logic is_exp(input logic [7:0] c);
      return (c == CH_LC_E) || (c == CH_UC_E);
   endfunction

endpackage

/* src/yaml_scalar_tag_classifier.sv */
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    ch, last, empty_req, quoted
// rsp_      out        rsp_valid/stall    kind (one word per last input word)
// csr_      in         csr_wr_en          schema_mode (2 bits)
//
// One input word per cycle unless req_stall is up; each word that carries a character advances the scan state by it.
// A word is held in the input register, then the result of a last word is loaded into
// the output register, from which kind is driven.
// Reset is synchronous: both registers empty, schema mode set to core.
// A stalled result holds the output register; a last word waiting behind it
// stalls the input, other words still flow through the scan state.
module yaml_scalar_tag_classifier
   import ystc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   input  logic       req_empty_req,
   input  logic       req_quoted,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   logic          in_valid_ff;
   scan_item_type in_item_ff;
   logic          rsp_valid_ff;
   kind_type      rsp_kind_ff;
   logic [1:0]    mode_ff;
   logic          advance;
   logic          accept;
   kind_type      kind;

   // A word leaves the input register unless its result has nowhere to go
   assign advance   = in_valid_ff &&
                      (!in_item_ff.last || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   ystc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .mode  (mode_ff),
      .kind  (kind)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= '{ch: req_ch, last: req_last, empty_req: req_empty_req,
                         quoted: req_quoted};
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_item_ff.last) begin
         rsp_kind_ff <= kind;
      end
   end

   // Schema mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CORE;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_item_ff.last && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_failsafe_str: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.last && mode_ff == MODE_FAILSAFE
      |=> rsp_valid_ff && rsp_kind_ff == KIND_STR)
      else $error("failsafe mode gave a kind other than str");

   a_quoted_str: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.last && in_item_ff.quoted
      |=> rsp_valid_ff && rsp_kind_ff == KIND_STR)
      else $error("quoted scalar gave a kind other than str");
`endif

endmodule

/* src/ystc_scan.sv */
module ystc_scan
   import ystc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  scan_item_type item,
   input  logic [1:0]    mode,
   output kind_type      kind
);

   int_phase_type         int_phase_ff,   int_phase_in;
   float_phase_type       float_phase_ff, float_phase_in;
   logic [KW_COUNT-1:0]   alive_ff,       alive_in;
   logic [2:0]            pos_ff,         pos_in;

   // Advance the keyword match and both automata by one character
   always_comb begin
      logic [7:0] c;
      c              = item.ch;
      int_phase_in   = int_phase_ff;
      float_phase_in = float_phase_ff;
      alive_in       = alive_ff;
      pos_in         = pos_ff;
      if (!item.empty_req) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (!(pos_ff < KW_LEN[k] && KW_TEXT[k][pos_ff] == c)) begin
               alive_in[k] = 1'b0;
            end
         end

         case (int_phase_ff)
            IP_START: begin
               if (is_sign(c))      int_phase_in = IP_SIGN;
               else if (c == CH_ZERO) int_phase_in = IP_ZERO;
               else if (is_dec(c))  int_phase_in = IP_DEC;
               else                 int_phase_in = IP_DEAD;
            end
            IP_SIGN: begin
               if (c == CH_ZERO)    int_phase_in = IP_ZERO;
               else if (is_dec(c))  int_phase_in = IP_DEC;
               else                 int_phase_in = IP_DEAD;
            end
            IP_ZERO: begin
               if (c == CH_LC_X)    int_phase_in = IP_HEX0;
               else if (c == CH_LC_O) int_phase_in = IP_OCT0;
               else if (is_dec(c))  int_phase_in = IP_DEC;
               else                 int_phase_in = IP_DEAD;
            end
            IP_DEC:  int_phase_in = is_dec(c) ? IP_DEC : IP_DEAD;
            IP_HEX0: int_phase_in = is_hex(c) ? IP_HEX : IP_DEAD;
            IP_HEX:  int_phase_in = is_hex(c) ? IP_HEX : IP_DEAD;
            IP_OCT0: int_phase_in = is_oct(c) ? IP_OCT : IP_DEAD;
            IP_OCT:  int_phase_in = is_oct(c) ? IP_OCT : IP_DEAD;
            default: int_phase_in = IP_DEAD;
         endcase

         case (float_phase_ff)
            FP_START: begin
               if (is_sign(c))      float_phase_in = FP_SIGN;
               else if (c == CH_DOT) float_phase_in = FP_DOT;
               else if (is_dec(c))  float_phase_in = FP_INT;
               else                 float_phase_in = FP_DEAD;
            end
            FP_SIGN: begin
               if (c == CH_DOT)     float_phase_in = FP_DOT;
               else if (is_dec(c))  float_phase_in = FP_INT;
               else                 float_phase_in = FP_DEAD;
            end
            FP_DOT: begin
               if (c == CH_LC_I)    float_phase_in = FP_I;
               else if (is_dec(c))  float_phase_in = FP_FRAC;
               else                 float_phase_in = FP_DEAD;
            end
            FP_FRAC, FP_INTDOT: begin
               if (is_exp(c))       float_phase_in = FP_E;
               else if (is_dec(c))  float_phase_in = float_phase_ff;
               else                 float_phase_in = FP_DEAD;
            end
            FP_INT: begin
               if (c == CH_DOT)     float_phase_in = FP_INTDOT;
               else if (is_exp(c))  float_phase_in = FP_E;
               else if (is_dec(c))  float_phase_in = FP_INT;
               else                 float_phase_in = FP_DEAD;
            end
            FP_E: begin
               if (is_sign(c))      float_phase_in = FP_ESIGN;
               else if (is_dec(c))  float_phase_in = FP_EXP;
               else                 float_phase_in = FP_DEAD;
            end
            FP_ESIGN, FP_EXP: float_phase_in = is_dec(c) ? FP_EXP : FP_DEAD;
            FP_I:    float_phase_in = (c == CH_LC_N) ? FP_IN : FP_DEAD;
            FP_IN:   float_phase_in = (c == CH_LC_F) ? FP_INF : FP_DEAD;
            default: float_phase_in = FP_DEAD;
         endcase

         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   // Resolve the kind from the state after this character
   always_comb begin
      logic                core;
      logic [KW_COUNT-1:0] mask;
      logic                hit;
      kind_type            kw_kind;
      core    = mode[1];
      mask    = core ? KW_ALL_MASK : KW_JSON_MASK;
      hit     = 1'b0;
      kw_kind = KIND_STR;
      // lowest index wins
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (alive_in[k] && mask[k] && pos_in == KW_LEN[k]) begin
            hit     = 1'b1;
            kw_kind = KW_KIND[k];
         end
      end

      if (item.quoted || mode == MODE_FAILSAFE) begin
         kind = KIND_STR;
      end else if (pos_in == 3'd0) begin
         kind = core ? KIND_NULL : KIND_STR;
      end else if (hit) begin
         kind = kw_kind;
      end else if (int_phase_in == IP_ZERO || int_phase_in == IP_DEC ||
                   int_phase_in == IP_HEX  || int_phase_in == IP_OCT) begin
         kind = KIND_INT;
      end else if (float_phase_in == FP_FRAC || float_phase_in == FP_INTDOT ||
                   float_phase_in == FP_EXP  || float_phase_in == FP_INF) begin
         kind = KIND_FLOAT;
      end else begin
         kind = KIND_STR;
      end
   end

   // Hold the scalar state; clear it after the last word
   always_ff @(posedge clock) begin
      if (reset) begin
         int_phase_ff   <= IP_START;
         float_phase_ff <= FP_START;
         alive_ff       <= KW_ALL_MASK;
         pos_ff         <= 3'd0;
      end else if (step) begin
         if (item.last) begin
            int_phase_ff   <= IP_START;
            float_phase_ff <= FP_START;
            alive_ff       <= KW_ALL_MASK;
            pos_ff         <= 3'd0;
         end else begin
            int_phase_ff   <= int_phase_in;
            float_phase_ff <= float_phase_in;
            alive_ff       <= alive_in;
            pos_ff         <= pos_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> pos_ff == 3'd0 && alive_ff == KW_ALL_MASK &&
                            int_phase_ff == IP_START && float_phase_ff == FP_START)
      else $error("scalar state not cleared after last word");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(pos_ff) && $stable(alive_ff) &&
                $stable(int_phase_ff) && $stable(float_phase_ff))
      else $error("scalar state changed without a word");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      step && !item.last && pos_ff == POS_MAX |=> pos_ff == POS_MAX)
      else $error("character count wrapped");
`endif

endmodule

/* tb/sv/tb.sv */
module tb
   import ystc_pkg::*;
();

   // Spare mode code, resolves like core
   localparam logic [1:0] MODE_SPARE = 2'd3;
   // Keywords allowed in json mode: null, true, false, .nan
   localparam logic [10:0] JSON_WORDS = 11'h491;
   localparam int WORD_COUNT = 11;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       empty_req;
      logic       quoted;
   } scan_word;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_last = 1'b0;
   logic       req_empty_req = 1'b0;
   logic       req_quoted = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_kind;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = MODE_CORE;

   // Scan state of the classifier as predicted here
   logic [1:0]      schema_sel = MODE_CORE;
   int_phase_type   scan_ip = IP_START;
   float_phase_type scan_fp = FP_START;
   logic [10:0]     kw_live = '1;
   logic [2:0]      scan_pos = 3'd0;

   scan_word     word_queue[$];
   scan_word     cur_word;
   kind_type     kind_due[$];
   kind_type     kind_want;
   byte unsigned scalar_text[$];
   int           send_wait = 0;
   int           stall_wait = 0;
   int           rsp_hold_left = 0;
   int           err_count = 0;
   int           cycle_count = 0;
   bit           gaps_on = 1'b1;

   yaml_scalar_tag_classifier uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .req_quoted    (req_quoted),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic string kw_word(input int k);
      case (k)
         0: return "null";
         1: return "Null";
         2: return "NULL";
         3: return "~";
         4: return "true";
         5: return "True";
         6: return "TRUE";
         7: return "false";
         8: return "False";
         9: return "FALSE";
         default: return ".nan";
      endcase
   endfunction

   function automatic kind_type kw_kind(input int k);
      if (k <= 3) return KIND_NULL;
      if (k <= 9) return KIND_BOOL;
      return KIND_FLOAT;
   endfunction

   function automatic bit digit_ch(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit sign_ch(input logic [7:0] c);
      return c == "+" || c == "-";
   endfunction

   function automatic int_phase_type int_after(input int_phase_type p, input logic [7:0] c);
      int_phase_type nx;
      nx = IP_DEAD;
      case (p)
         IP_START, IP_SIGN: begin
            if (p == IP_START && sign_ch(c)) nx = IP_SIGN;
            else if (c == "0") nx = IP_ZERO;
            else if (digit_ch(c)) nx = IP_DEC;
         end
         IP_ZERO: begin
            if (c == "x") nx = IP_HEX0;
            else if (c == "o") nx = IP_OCT0;
            else if (digit_ch(c)) nx = IP_DEC;
         end
         IP_DEC: if (digit_ch(c)) nx = IP_DEC;
         IP_HEX0, IP_HEX: begin
            if (digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) nx = IP_HEX;
         end
         IP_OCT0, IP_OCT: if (c >= "0" && c <= "7") nx = IP_OCT;
         default: nx = IP_DEAD;
      endcase
      return nx;
   endfunction

   function automatic float_phase_type float_after(input float_phase_type p,
                                                   input logic [7:0] c);
      float_phase_type nx;
      bit exp_ch;
      nx = FP_DEAD;
      exp_ch = (c == "e" || c == "E");
      case (p)
         FP_START, FP_SIGN: begin
            if (p == FP_START && sign_ch(c)) nx = FP_SIGN;
            else if (c == ".") nx = FP_DOT;
            else if (digit_ch(c)) nx = FP_INT;
         end
         FP_DOT: begin
            if (c == "i") nx = FP_I;
            else if (digit_ch(c)) nx = FP_FRAC;
         end
         FP_FRAC, FP_INTDOT: begin
            if (exp_ch) nx = FP_E;
            else if (digit_ch(c)) nx = p;
         end
         FP_INT: begin
            if (c == ".") nx = FP_INTDOT;
            else if (exp_ch) nx = FP_E;
            else if (digit_ch(c)) nx = FP_INT;
         end
         FP_E: begin
            if (sign_ch(c)) nx = FP_ESIGN;
            else if (digit_ch(c)) nx = FP_EXP;
         end
         FP_ESIGN, FP_EXP: if (digit_ch(c)) nx = FP_EXP;
         FP_I: if (c == "n") nx = FP_IN;
         FP_IN: if (c == "f") nx = FP_INF;
         default: nx = FP_DEAD;
      endcase
      return nx;
   endfunction

   // Advance every automaton by one character
   function automatic void absorb_char(input logic [7:0] c);
      string w;
      int k;
      for (k = 0; k < WORD_COUNT; k++) begin
         w = kw_word(k);
         if (kw_live[k] && (scan_pos >= w.len() || w[scan_pos] != c)) kw_live[k] = 1'b0;
      end
      scan_ip = int_after(scan_ip, c);
      scan_fp = float_after(scan_fp, c);
      if (scan_pos != 3'd7) scan_pos = scan_pos + 3'd1;
   endfunction

   function automatic kind_type resolve_kind(input logic quoted);
      bit core;
      logic [10:0] allowed;
      string w;
      int k;
      if (quoted || schema_sel == MODE_FAILSAFE) return KIND_STR;
      core = schema_sel[1];
      if (scan_pos == 3'd0) return core ? KIND_NULL : KIND_STR;
      allowed = core ? 11'h7FF : JSON_WORDS;
      for (k = 0; k < WORD_COUNT; k++) begin
         w = kw_word(k);
         if (kw_live[k] && allowed[k] && scan_pos == w.len()) return kw_kind(k);
      end
      if (scan_ip inside {IP_ZERO, IP_DEC, IP_HEX, IP_OCT}) return KIND_INT;
      if (scan_fp inside {FP_FRAC, FP_INTDOT, FP_EXP, FP_INF}) return KIND_FLOAT;
      return KIND_STR;
   endfunction

   // Fold one accepted word into the scan state; a last word yields a kind
   function automatic void take_word(input scan_word w);
      if (!w.empty_req) absorb_char(w.ch);
      if (w.last) begin
         kind_due.push_back(resolve_kind(w.quoted));
         scan_ip = IP_START;
         scan_fp = FP_START;
         kw_live = '1;
         scan_pos = 3'd0;
      end
   endfunction

   function automatic int draw_gap();
      if (!gaps_on || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   task automatic report_mismatch(input string msg);
      if (err_count < 40) $display("ERROR: %s", msg);
      err_count++;
   endtask

   // Sender: present queued words, hold while stalled, wait between words
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) take_word(cur_word);
         if (send_wait > 0) begin
            send_wait = send_wait - 1;
            req_valid <= 1'b0;
         end else if (word_queue.size() > 0) begin
            cur_word = word_queue.pop_front();
            req_ch <= cur_word.ch;
            req_last <= cur_word.last;
            req_empty_req <= cur_word.empty_req;
            req_quoted <= cur_word.quoted;
            req_valid <= 1'b1;
            send_wait = draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: check each kind against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (kind_due.size() == 0) begin
               report_mismatch($sformatf("unexpected kind %0d", rsp_kind));
            end else begin
               kind_want = kind_due.pop_front();
               if (rsp_kind !== kind_want)
                  report_mismatch($sformatf("kind got %0d want %0d", rsp_kind, kind_want));
            end
            stall_wait = draw_gap();
         end
         if (stall_wait > 0) begin
            stall_wait = stall_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (rsp_hold_left > 0);
         end
      end
   end

   // Count down a long receiver hold-off
   always @(posedge clock) begin
      if (rsp_hold_left > 0) rsp_hold_left <= rsp_hold_left - 1;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic push_word(input logic [7:0] ch, input logic last, input logic empty_req,
                            input logic quoted);
      scan_word w;
      w.ch = ch;
      w.last = last;
      w.empty_req = empty_req;
      w.quoted = quoted;
      word_queue.push_back(w);
   endtask

   task automatic push_text(input string s, input logic quoted);
      int i;
      if (s.len() == 0) push_word(8'h00, 1'b1, 1'b1, quoted);
      for (i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1, 1'b0, quoted);
   endtask

   function automatic void add_chars(input string pool, input int cnt);
      int i;
      for (i = 0; i < cnt; i++) scalar_text.push_back(pool[$urandom_range(0, pool.len() - 1)]);
   endfunction

   function automatic void add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) scalar_text.push_back(s[i]);
   endfunction

   function automatic void maybe_sign();
      if ($urandom_range(0, 2) == 0) add_chars("+-", 1);
   endfunction

   // Build one scalar, mostly well formed, and queue its words
   task automatic queue_random_scalar(output int n_words);
      string digits;
      string swaps;
      logic quoted;
      bit end_empty;
      int i;
      digits = "0123456789";
      swaps = "lLuUeE.~xn0";
      scalar_text.delete();
      n_words = 0;
      case ($urandom_range(0, 11))
         0, 1: begin
            add_text(kw_word($urandom_range(0, WORD_COUNT - 1)));
            if ($urandom_range(0, 3) == 0)
               scalar_text[$urandom_range(0, scalar_text.size() - 1)] =
                  swaps[$urandom_range(0, swaps.len() - 1)];
            if ($urandom_range(0, 5) == 0) add_chars("elsE.n", 1);
         end
         2: begin
            maybe_sign();
            add_chars(digits, $urandom_range(1, 6));
         end
         3: begin
            maybe_sign();
            add_text("0x");
            add_chars("0123456789abcdefABCDEFgx", $urandom_range(0, 4));
         end
         4: begin
            maybe_sign();
            add_text("0o");
            add_chars("012345678", $urandom_range(0, 4));
         end
         5, 6: begin
            maybe_sign();
            add_chars(digits, $urandom_range(0, 3));
            if ($urandom_range(0, 3) != 0) add_text(".");
            add_chars(digits, $urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) begin
               add_chars("eE", 1);
               maybe_sign();
               add_chars(digits, $urandom_range(0, 2));
            end
         end
         7: begin
            maybe_sign();
            if ($urandom_range(0, 1) == 0) add_text(".inf");
            else add_text(".nan");
            if ($urandom_range(0, 3) == 0) void'(scalar_text.pop_back());
         end
         8: begin
            for (i = $urandom_range(1, 8); i > 0; i--)
               scalar_text.push_back(8'($urandom_range(0, 255)));
         end
         9: add_chars("0123456789+-.eExoinafulTFNLsr~", $urandom_range(1, 9));
         10: begin
            add_text("0");
            add_chars("0123456789xo", $urandom_range(0, 3));
         end
         default: ;
      endcase
      quoted = ($urandom_range(0, 7) == 0);
      end_empty = (scalar_text.size() == 0) || ($urandom_range(0, 7) == 0);
      for (i = 0; i < scalar_text.size(); i++) begin
         // drop in a word that carries no character
         if ($urandom_range(0, 11) == 0)
            push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'($urandom_range(0, 1)));
         push_word(scalar_text[i], !end_empty && i == scalar_text.size() - 1, 1'b0,
                   (i == scalar_text.size() - 1) ? quoted : logic'($urandom_range(0, 1)));
         n_words++;
      end
      if (end_empty) begin
         push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1, quoted);
         n_words++;
      end
   endtask

   task automatic run_random(input int target);
      int sent, n;
      sent = 0;
      while (sent < target) begin
         queue_random_scalar(n);
         sent += n;
      end
   endtask

   // Wait until no word is pending and every kind has arrived
   task automatic wait_quiet();
      @(negedge clock);
      while (word_queue.size() != 0 || req_valid || kind_due.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] m);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      schema_sel = m;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed scalars under the reset mode (core)
      push_text("", 1'b0);
      push_text("~", 1'b0);
      push_text("0x1F", 1'b0);
      push_text("-.inf", 1'b0);
      push_text("1e5", 1'b0);
      push_text("0o7", 1'b0);
      push_text("7", 1'b1);
      push_word("7", 1'b0, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b1, 1'b0);
      push_word("7", 1'b1, 1'b0, 1'b0);
      push_word("1", 1'b0, 1'b0, 1'b0);
      push_word(8'hFF, 1'b1, 1'b1, 1'b0);
      push_word(8'hFF, 1'b1, 1'b0, 1'b0);
      push_word(8'h00, 1'b1, 1'b0, 1'b0);
      wait_quiet();

      write_mode(MODE_JSON);
      run_random(250);
      wait_quiet();

      // Back-to-back words, no gaps on either side
      write_mode(MODE_FAILSAFE);
      gaps_on = 1'b0;
      run_random(150);
      wait_quiet();

      write_mode(MODE_SPARE);
      gaps_on = 1'b1;
      run_random(150);
      wait_quiet();

      // Hold off the receiver while words keep coming, so the input backs up
      write_mode(MODE_CORE);
      rsp_hold_left <= LONG_HOLD;
      run_random(450);
      wait_quiet();

      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/ystc_pkg.sv
src/ystc_scan.sv
src/yaml_scalar_tag_classifier.sv
tb/sv/tb.sv
